[sv/lbs_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the skinning engine.
// No dependencies; lbs_div and linear_blend_skinning import this package.
package lbs_pkg;

  // Sizes and fixed-point format
  localparam int MAX_VERTICES = 1024;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int FRAC_BITS    = 16;
  localparam int Q_W          = 32;
  localparam int W_W          = 17;
  localparam int WSUM_W       = 20;
  localparam int ONE_Q        = 1 << FRAC_BITS;
  localparam int WSUM_MAX     = (1 << WSUM_W) - 1;
  localparam int N_ELEM       = 12;
  localparam int ELEM_W       = 4;
  localparam int MAT_W        = N_ELEM * Q_W;
  localparam int PROD_W       = 2 * Q_W;
  localparam int ACC_W        = 50;
  localparam int DIV_STEPS    = Q_W + 1;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

  // Item function codes
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_INFLUE  = 2'd1;
  localparam logic [1:0] FUNC_DEFORM  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR   = 2'd3;

  // Link modes
  localparam logic [1:0] MODE_NORM    = 2'd0;
  localparam logic [1:0] MODE_PRODUCT = 2'd1;
  localparam logic [1:0] MODE_TOTAL   = 2'd2;

  // Configuration register indexes
  localparam logic REG_LINK_MODE    = 1'b0;
  localparam logic REG_VERTEX_COUNT = 1'b1;

  typedef logic signed [Q_W-1:0] q_t;

  // Request to and response from the divider
  typedef struct packed {
    logic              start;
    logic              neg;
    logic [ACC_W-1:0]  mag;
    logic [WSUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    q_t   quo;
  } div_rsp_t;

  // Saturate a wide signed value to the Q16.16 word.
  function automatic q_t sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] max_v;
    logic signed [ACC_W-1:0] min_v;
    max_v = ACC_W'($signed({1'b0, {(Q_W-1){1'b1}}}));
    min_v = ACC_W'($signed({1'b1, {(Q_W-1){1'b0}}}));
    if (v > max_v) begin
      return max_v[Q_W-1:0];
    end else if (v < min_v) begin
      return min_v[Q_W-1:0];
    end
    return v[Q_W-1:0];
  endfunction

endpackage

[sv/lbs_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/lbs_div.sv]
`timescale 1ns / 1ps
// Bit-serial restoring divider: saturated (magnitude << FRAC_BITS) / divisor.
// Depends on lbs_pkg.
module lbs_div import lbs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WSUM_W-1:0]    rem;
  logic [WSUM_W-1:0]    dq;
  logic [DIV_STEPS-1:0] nlow;
  logic [DIV_STEPS-1:0] quo;
  logic                 sat;
  logic                 neg;
  logic                 ovf;
  logic [WSUM_W:0]      rem2;
  logic                 ge;
  logic                 big_pos;
  logic                 big_neg;

  // A quotient of 2^33 or more saturates whatever its sign.
  assign ovf  = req.mag >= (ACC_W'(req.divisor) << (DIV_STEPS - FRAC_BITS));
  assign rem2 = {rem, nlow[DIV_STEPS-1]};
  assign ge   = rem2 >= {1'b0, dq};

  // Iteration: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        neg <= req.neg;
        dq  <= req.divisor;
        quo <= '0;
        if (ovf) begin
          sat  <= 1'b1;
          done <= 1'b1;
        end else begin
          sat  <= 1'b0;
          rem  <= WSUM_W'(req.mag >> (DIV_STEPS - FRAC_BITS));
          nlow <= {req.mag[DIV_STEPS-FRAC_BITS-1:0], FRAC_BITS'(0)};
          cnt  <= DIV_CNT_W'(DIV_STEPS);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= ge ? WSUM_W'(rem2 - {1'b0, dq}) : rem2[WSUM_W-1:0];
        quo  <= {quo[DIV_STEPS-2:0], ge};
        nlow <= {nlow[DIV_STEPS-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Signed, saturated result.
  assign big_pos = quo > DIV_STEPS'({1'b0, {(Q_W-1){1'b1}}});
  assign big_neg = quo > DIV_STEPS'({1'b1, {(Q_W-1){1'b0}}});

  always_comb begin
    rsp.done = done;
    if (neg) begin
      rsp.quo = (sat || big_neg) ? q_t'({1'b1, {(Q_W-1){1'b0}}})
                                 : q_t'(Q_W'(DIV_STEPS'(0) - quo));
    end else begin
      rsp.quo = (sat || big_pos) ? q_t'({1'b0, {(Q_W-1){1'b1}}})
                                 : q_t'(quo[Q_W-1:0]);
    end
  end

endmodule

[sv/linear_blend_skinning.sv]
`timescale 1ns / 1ps
// Linear blend skinning engine: per-vertex matrix and weight stores with the
// sequencer and shared multiplier. Depends on lbs_pkg, lbs_ram and lbs_div.
//
// The engine works on one item at a time. Load and clear items finish in their
// transfer cycle. A deform, or an influence of nonzero weight, to a vertex in
// range reads its vertex entry from the registered RAM, then runs its products
// through one shared 32x32 multiplier, each in a multiply state and an accumulate
// state: an influence in the accumulating modes runs 12 products, an influence in
// additive product mode 48 (12 weight products and 36 matrix products), a deform
// in total-one mode 12 and a deform in the other modes 9, and in normalize mode
// each of its three rows also waits on the bit-serial divider. A deform of a
// vertex with zero weight skips the products. A finished result sits in the output
// register, so the next item is taken while it waits. The vertex stores need no
// clearing pass: an entry is defined once a clear item has written it.
module linear_blend_skinning import lbs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CNT_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             func,
  input  logic [1:0]             row_select,
  input  logic signed [Q_W-1:0]  elem_a,
  input  logic signed [Q_W-1:0]  elem_b,
  input  logic signed [Q_W-1:0]  elem_c,
  input  logic signed [Q_W-1:0]  elem_d,
  input  logic [IDX_W-1:0]       vertex_index,
  input  logic [W_W-1:0]         weight,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [IDX_W-1:0]       out_index,
  output logic signed [Q_W-1:0]  pos_x,
  output logic signed [Q_W-1:0]  pos_y,
  output logic signed [Q_W-1:0]  pos_z,
  output logic                   influenced
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FETCH = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_ACC   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_WRITE = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state;

  logic [1:0]       link_mode;
  logic [CNT_W-1:0] vertex_count;

  q_t bone [N_ELEM];
  q_t m    [N_ELEM];
  q_t a    [N_ELEM];
  q_t res  [N_ELEM];
  q_t src  [3];
  q_t pos  [3];

  logic [IDX_W-1:0]  idx_q;
  logic [W_W-1:0]    w_q;
  logic [WSUM_W-1:0] wsum;
  logic              is_def;
  logic              is_mul;
  logic              phase_b;
  logic              infl;
  logic [1:0]        r;
  logic [1:0]        c;
  logic [1:0]        k;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic              in_xfer;
  logic              idx_ok;
  logic [W_W-1:0]    w_clamp;
  logic              mat_we;
  logic [IDX_W-1:0]  waddr;
  logic [MAT_W-1:0]  mat_wdata;
  logic [MAT_W-1:0]  mat_rdata;
  logic [WSUM_W-1:0] wt_wdata;
  logic [WSUM_W-1:0] wt_rdata;
  logic [WSUM_W:0]   wsum_add;

  logic [ELEM_W-1:0] m_addr;
  logic [ELEM_W-1:0] a_addr;
  q_t                m_rd;
  q_t                a_rd;
  q_t                src_k;
  q_t                src_r;
  q_t                opa;
  q_t                opb;
  q_t                one_minus_sum;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [ACC_W-1:0]  qx;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  sum_n;
  q_t                sum_sat;
  logic [1:0]        klast;
  logic              rc_last;
  logic              row_end;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // Handshakes
  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign in_xfer   = in_valid & in_ready;
  assign idx_ok    = {1'b0, vertex_index} < vertex_count;
  assign w_clamp   = (weight > W_W'(ONE_Q)) ? W_W'(ONE_Q) : weight;

  // Vertex stores: one row holds the whole 3x4 matrix.
  lbs_ram #(.WIDTH(MAT_W), .DEPTH(MAX_VERTICES)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (waddr),
    .wdata (mat_wdata),
    .raddr (vertex_index),
    .rdata (mat_rdata)
  );

  lbs_ram #(.WIDTH(WSUM_W), .DEPTH(MAX_VERTICES)) u_wt_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (waddr),
    .wdata (wt_wdata),
    .raddr (vertex_index),
    .rdata (wt_rdata)
  );

  // Store write: a clear in the transfer cycle, or the write-back of an influence.
  assign mat_we   = (in_xfer && func == FUNC_CLEAR && idx_ok) || (state == ST_WRITE);
  assign waddr    = (state == ST_WRITE) ? idx_q : vertex_index;
  assign wsum_add = {1'b0, wsum} + (WSUM_W+1)'(w_q);

  always_comb begin
    if (state == ST_WRITE) begin
      for (int i = 0; i < N_ELEM; i++) begin
        mat_wdata[i*Q_W +: Q_W] = is_mul ? res[i] : m[i];
      end
      if (is_mul) begin
        wt_wdata = WSUM_W'(ONE_Q);
      end else begin
        wt_wdata = (wsum_add > (WSUM_W+1)'(WSUM_MAX)) ? WSUM_W'(WSUM_MAX)
                                                      : wsum_add[WSUM_W-1:0];
      end
    end else begin
      // Cleared entry: identity in additive product mode, zero otherwise.
      mat_wdata = '0;
      if (link_mode == MODE_PRODUCT) begin
        for (int i = 0; i < 3; i++) begin
          mat_wdata[(i*5)*Q_W +: Q_W] = Q_W'(ONE_Q);
        end
      end
      wt_wdata = '0;
    end
  end

  // Register file addressing: one read of m and of a per cycle.
  always_comb begin
    if (state == ST_MUL) begin
      m_addr = is_def ? {r, k} : {k, c};
      a_addr = {r, k};
    end else begin
      m_addr = is_def ? {r, 2'd3} : {r, c};
      a_addr = {r, 2'd3};
    end
  end

  assign m_rd = m[m_addr];
  assign a_rd = a[a_addr];

  always_comb begin
    case (k)
      2'd0:    src_k = src[0];
      2'd1:    src_k = src[1];
      default: src_k = src[2];
    endcase
    case (r)
      2'd0:    src_r = src[0];
      2'd1:    src_r = src[1];
      default: src_r = src[2];
    endcase
  end

  assign one_minus_sum = q_t'(Q_W'(ONE_Q)) - $signed(Q_W'(wsum));

  // Multiplier operand selection.
  always_comb begin
    if (is_def) begin
      if (k == 2'd3) begin
        opa = src_r;
        opb = one_minus_sum;
      end else begin
        opa = m_rd;
        opb = src_k;
      end
    end else if (phase_b) begin
      opa = a_rd;
      opb = m_rd;
    end else begin
      opa = $signed(Q_W'(w_q));
      opb = bone[{r, c}];
    end
  end

  // Rounded product and accumulation.
  assign prod_rnd = prod + PROD_W'(1 << (FRAC_BITS - 1));
  assign qx       = ACC_W'($signed(prod_rnd[PROD_W-1:FRAC_BITS]));
  assign klast    = (link_mode == MODE_TOTAL) ? 2'd3 : 2'd2;
  assign rc_last  = (r == 2'd2) && (c == 2'd3);
  assign row_end  = (r == 2'd2);

  always_comb begin
    if (is_def) begin
      base = (k == 2'd0) ? ACC_W'(m_rd) : acc;
    end else if (phase_b) begin
      base = (k != 2'd0) ? acc : ((c == 2'd3) ? ACC_W'(a_rd) : '0);
    end else if (is_mul) begin
      base = (r == c) ? ($signed(ACC_W'(ONE_Q)) - $signed(ACC_W'(w_q))) : '0;
    end else begin
      base = ACC_W'(m_rd);
    end
  end

  assign sum_n   = base + qx;
  assign sum_sat = sat32(sum_n);

  // Divider for normalize mode.
  always_comb begin
    div_req.start   = (state == ST_ACC) && is_def && (k == klast)
                      && (link_mode == MODE_NORM);
    div_req.neg     = sum_n < 0;
    div_req.mag     = (sum_n < 0) ? ACC_W'(-sum_n) : ACC_W'(sum_n);
    div_req.divisor = wsum;
  end

  lbs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration registers and bone transform.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode    <= MODE_NORM;
      vertex_count <= '0;
      for (int i = 0; i < N_ELEM; i++) begin
        bone[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LINK_MODE:    link_mode    <= cfg_data[1:0];
          REG_VERTEX_COUNT: vertex_count <= cfg_data;
          default:          link_mode    <= link_mode;
        endcase
      end
      if (in_xfer && func == FUNC_LOAD && row_select != 2'd3) begin
        bone[{row_select, 2'd0}] <= elem_a;
        bone[{row_select, 2'd1}] <= elem_b;
        bone[{row_select, 2'd2}] <= elem_c;
        bone[{row_select, 2'd3}] <= elem_d;
      end
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The output register empties on a transfer unless it is reloaded below.
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          idx_q  <= vertex_index;
          w_q    <= w_clamp;
          src[0] <= elem_a;
          src[1] <= elem_b;
          src[2] <= elem_c;
          is_def <= (func == FUNC_DEFORM);
          if (in_xfer && idx_ok &&
              (func == FUNC_DEFORM || (func == FUNC_INFLUE && w_clamp != '0))) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          for (int i = 0; i < N_ELEM; i++) begin
            m[i] <= mat_rdata[i*Q_W +: Q_W];
          end
          wsum    <= wt_rdata;
          is_mul  <= !is_def && (link_mode == MODE_PRODUCT);
          phase_b <= 1'b0;
          r       <= '0;
          c       <= '0;
          k       <= '0;
          infl    <= (wt_rdata != '0);
          if (is_def && wt_rdata == '0) begin
            pos[0] <= src[0];
            pos[1] <= src[1];
            pos[2] <= src[2];
            state  <= ST_DONE;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= opa * opb;
          state <= ST_ACC;
        end
        ST_ACC: begin
          acc <= sum_n;
          if (is_def) begin
            if (k == klast) begin
              k <= '0;
              if (link_mode == MODE_NORM) begin
                state <= ST_DIV;
              end else begin
                pos[r] <= sum_sat;
                r      <= r + 1'b1;
                state  <= row_end ? ST_DONE : ST_MUL;
              end
            end else begin
              k     <= k + 1'b1;
              state <= ST_MUL;
            end
          end else if (phase_b) begin
            if (k == 2'd2) begin
              res[{r, c}] <= sum_sat;
              k           <= '0;
              c           <= c + 1'b1;
              if (c == 2'd3) begin
                r <= r + 1'b1;
              end
              state <= rc_last ? ST_WRITE : ST_MUL;
            end else begin
              k     <= k + 1'b1;
              state <= ST_MUL;
            end
          end else begin
            // Weighted bone element: into a in product mode, added to m otherwise.
            if (is_mul) begin
              a[{r, c}] <= sum_sat;
            end else begin
              m[{r, c}] <= sum_sat;
            end
            c <= c + 1'b1;
            if (rc_last) begin
              r <= '0;
              if (is_mul) begin
                phase_b <= 1'b1;
                state   <= ST_MUL;
              end else begin
                state <= ST_WRITE;
              end
            end else begin
              if (c == 2'd3) begin
                r <= r + 1'b1;
              end
              state <= ST_MUL;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            pos[r] <= div_rsp.quo;
            r      <= r + 1'b1;
            state  <= row_end ? ST_DONE : ST_MUL;
          end
        end
        ST_WRITE: begin
          state <= ST_IDLE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_index  <= idx_q;
            pos_x      <= pos[0];
            pos_y      <= pos[1];
            pos_z      <= pos[2];
            influenced <= infl;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Store writes happen only for a clear transfer or the write-back step.
  a_store_write: assert property (@(posedge clk) disable iff (rst)
    mat_we |-> (state == ST_IDLE || state == ST_WRITE))
    else $error("vertex store written outside idle or write-back");

  // A fetch always follows an input transfer.
  a_fetch_after_xfer: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> $past(in_xfer))
    else $error("fetch without a preceding transfer");

  // The divider only answers while the sequencer waits for it.
  a_div_done_waits: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("divider result arrived outside the wait state");

  // A new result is loaded only from the done state.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("output loaded outside the done state");

endmodule
